// ----- rtl/core/mie_pkg.sv -----
// Shared types, constants and the microcode table for the modular inverse block.
// Used by mie_seq, mie_datapath and modular_inverse_ext_euclid; depends on nothing.
`default_nettype none

package mie_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam int STEP_W = 3;

    // datapath operations, one-hot
    typedef enum logic [5:0] {
        OP_NOP    = 6'b000001,
        OP_LOAD   = 6'b000010,
        OP_INIT   = 6'b000100,
        OP_DIV    = 6'b001000,
        OP_UPDATE = 6'b010000,
        OP_FINISH = 6'b100000
    } op_t;

    // jump conditions, one-hot
    typedef enum logic [5:0] {
        COND_NEXT     = 6'b000001,
        COND_ALWAYS   = 6'b000010,
        COND_NO_INPUT = 6'b000100,
        COND_REM_ZERO = 6'b001000,
        COND_CNT_NZ   = 6'b010000,
        COND_OUT_BUSY = 6'b100000
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic rem_zero;
        logic cnt_nz;
        logic out_busy;
    } flags_t;

    localparam logic [STEP_W-1:0] STEP_LOAD   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_TEST   = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_DIV    = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_UPDATE = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_FINISH = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_RETURN = STEP_W'(5);

    // control store: one word per step, jump taken when cond holds
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        unique case (step)
            STEP_LOAD:   w = '{op: OP_LOAD,   cond: COND_NO_INPUT, target: STEP_LOAD};
            STEP_TEST:   w = '{op: OP_INIT,   cond: COND_REM_ZERO, target: STEP_FINISH};
            STEP_DIV:    w = '{op: OP_DIV,    cond: COND_CNT_NZ,   target: STEP_DIV};
            STEP_UPDATE: w = '{op: OP_UPDATE, cond: COND_ALWAYS,   target: STEP_TEST};
            STEP_FINISH: w = '{op: OP_FINISH, cond: COND_OUT_BUSY, target: STEP_FINISH};
            STEP_RETURN: w = '{op: OP_NOP,    cond: COND_ALWAYS,   target: STEP_LOAD};
            default:     w = '{op: OP_NOP,    cond: COND_ALWAYS,   target: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/modular_inverse_ext_euclid.sv -----
// Top level of the 64-bit modular inverse (iterative extended Euclid).
// Instantiates mie_seq and mie_datapath; depends on mie_pkg.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_value[63:0], s_modulus[63:0]
//   m_       out  m_valid/m_ready    m_inverse[63:0]
//
// one transaction at a time; each Euclid pass is a test step, the bit-serial
// divider, which also forms q*x, and an update step
// the number of passes is up to about 93
// a finished result waits in the output register while the next
// transaction is accepted; a stalled output holds the sequencer at its finish step
// reset (synchronous, active low) returns the sequencer to its load step
`default_nettype none

module modular_inverse_ext_euclid
    import mie_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [DATA_W-1:0] s_value,
    input  wire logic [DATA_W-1:0] s_modulus,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_inverse
);

    ctrl_t  ctrl;
    flags_t flags;

    mie_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    mie_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .flags     (flags),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .s_modulus (s_modulus),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_inverse (m_inverse)
    );

    // accepting a transaction moves the sequencer out of its load step and drops s_ready
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // results only come out of the finish step
    a_emit_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ctrl.op == OP_FINISH))
        else $error("result raised outside finish step");

    // the divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_DIV) |-> !flags.rem_zero)
        else $error("division step with zero divisor");

endmodule

`default_nettype wire

// ----- rtl/core/mie_seq.sv -----
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on mie_pkg.
`default_nettype none

module mie_seq
    import mie_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire flags_t flags,
    output ctrl_t       ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              taken;

    assign ctrl = ucode(step_reg);

    always_comb begin
        unique case (ctrl.cond)
            COND_NEXT:     taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_NO_INPUT: taken = !flags.in_valid;
            COND_REM_ZERO: taken = flags.rem_zero;
            COND_CNT_NZ:   taken = flags.cnt_nz;
            COND_OUT_BUSY: taken = flags.out_busy;
            default:       taken = 1'b1;
        endcase
        step_next = taken ? ctrl.target : step_reg + STEP_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_LOAD;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mie_datapath.sv -----
// Euclid datapath: bit-serial restoring divider with a Horner product of
// quotient and coefficient, coefficient update and output register. Depends on mie_pkg.
`default_nettype none

module mie_datapath
    import mie_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ctrl_t             ctrl,
    output flags_t                 flags,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [DATA_W-1:0] s_value,
    input  wire logic [DATA_W-1:0] s_modulus,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_inverse
);

    logic [DATA_W-1:0] rem_reg,   rem_next;    // current divisor a
    logic [DATA_W-1:0] prev_reg,  prev_next;   // dividend b
    logic [DATA_W-1:0] coef_reg,  coef_next;   // x
    logic [DATA_W-1:0] pcoef_reg, pcoef_next;  // y
    logic [DATA_W-1:0] mod_reg,   mod_next;
    logic [DATA_W-1:0] dvd_reg,   dvd_next;
    logic [DATA_W-1:0] part_reg,  part_next;
    logic [DATA_W-1:0] prod_reg,  prod_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [DATA_W-1:0] inv_reg,   inv_next;
    logic              m_valid_reg, m_valid_next;

    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;
    logic              qbit;
    logic              out_busy;
    logic              load;
    logic              emit;

    assign s_ready   = (ctrl.op == OP_LOAD);
    assign load      = s_valid && s_ready;
    assign out_busy  = m_valid_reg && !m_ready;
    assign emit      = (ctrl.op == OP_FINISH) && !out_busy;
    assign m_valid   = m_valid_reg;
    assign m_inverse = inv_reg;

    assign flags = '{in_valid: s_valid,
                     rem_zero: (rem_reg == '0),
                     cnt_nz:   (cnt_reg != '0),
                     out_busy: out_busy};

    // one quotient bit per cycle, msb first
    assign shifted = {part_reg, dvd_reg[DATA_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, rem_reg};
    assign qbit    = !diff[DATA_W+1];

    always_comb begin
        rem_next     = rem_reg;
        prev_next    = prev_reg;
        coef_next    = coef_reg;
        pcoef_next   = pcoef_reg;
        mod_next     = mod_reg;
        dvd_next     = dvd_reg;
        part_next    = part_reg;
        prod_next    = prod_reg;
        cnt_next     = cnt_reg;
        inv_next     = inv_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (ctrl.op)
            OP_LOAD: begin
                if (load) begin
                    rem_next   = s_value;
                    prev_next  = s_modulus;
                    mod_next   = s_modulus;
                    coef_next  = DATA_W'(1);
                    pcoef_next = '0;
                end
            end
            OP_INIT: begin
                dvd_next  = prev_reg;
                part_next = '0;
                prod_next = '0;
                cnt_next  = CNT_W'(DATA_W - 1);
            end
            OP_DIV: begin
                dvd_next  = {dvd_reg[DATA_W-2:0], 1'b0};
                part_next = qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
                // q*x accumulated alongside the quotient bits, wrapping
                prod_next = {prod_reg[DATA_W-2:0], 1'b0} + (qbit ? coef_reg : '0);
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            OP_UPDATE: begin
                prev_next  = rem_reg;
                rem_next   = part_reg;
                pcoef_next = coef_reg;
                coef_next  = pcoef_reg - prod_reg;
            end
            OP_FINISH: begin
                if (emit) begin
                    inv_next     = pcoef_reg[DATA_W-1] ? pcoef_reg + mod_reg : pcoef_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        prev_reg  <= prev_next;
        coef_reg  <= coef_next;
        pcoef_reg <= pcoef_next;
        mod_reg   <= mod_next;
        dvd_reg   <= dvd_next;
        part_reg  <= part_next;
        prod_reg  <= prod_next;
        cnt_reg   <= cnt_next;
        inv_reg   <= inv_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire
